/* rtl/core/rbf_pkg.sv */
// ----------------------------------------------------------------------------
// rbf_pkg: shared types and constants of the ray/box first-hit finder
// Holds the box table entry layout, the status and function codes, the
// register indexes and the command/status structs between controller and
// datapath.
// ----------------------------------------------------------------------------
package rbf_pkg;

    localparam int COORD_W  = 16;
    localparam int CORNER_W = 18;
    localparam int DIFF_W   = 19;
    localparam int QUO_W    = 18;
    localparam int SLAB_W   = 20;
    localparam int PROD_W   = 33;
    localparam int CFG_IDX_W = 2;

    // Interval bounds used before any slab has narrowed them.
    localparam logic signed [SLAB_W-1:0] T_NEG_INF = -20'sd262144;
    localparam logic signed [SLAB_W-1:0] T_POS_INF = 20'sd262144;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_CAST = 1'b1;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_HIT   = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic                     enemy;
        logic [2:0][CORNER_W-1:0] hi;
        logic [2:0][CORNER_W-1:0] lo;
    } box_entry_t;

    typedef struct packed {
        logic       accept;
        logic       rd;
        logic       div_start;
        logic       div_hi;
        logic       upd;
        logic       chk;
        logic       next_box;
        logic       mul;
        logic       acc;
        logic       out_load;
        logic [1:0] axis;
        logic [1:0] result;
    } dp_cmd_t;

    typedef struct packed {
        logic is_full;
        logic count_zero;
        logic last_box;
        logic d_zero;
        logic in_slab;
        logic div_done;
        logic slab_miss;
        logic t_hit;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/core/rbf_datapath.sv */
// ----------------------------------------------------------------------------
// rbf_datapath: box table, slab divider, interval tracking and hit point
// Stores boxes as corners, runs one bit-serial division at a time and keeps
// the entry/exit interval and the registered result word.
// ----------------------------------------------------------------------------
module rbf_datapath #(
    parameter int MAX_BOXES = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rbf_pkg::dp_cmd_t            cmd,
    output rbf_pkg::dp_stat_t           stat,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [15:0]                 cfg_wdata,
    input  logic                        s_func,
    input  logic signed [15:0]          s_box_center_x,
    input  logic signed [15:0]          s_box_center_y,
    input  logic signed [15:0]          s_box_center_z,
    input  logic [15:0]                 s_box_extent_x,
    input  logic [15:0]                 s_box_extent_y,
    input  logic [15:0]                 s_box_extent_z,
    input  logic                        s_box_is_enemy,
    input  logic signed [15:0]          s_ray_dir_x,
    input  logic signed [15:0]          s_ray_dir_y,
    input  logic signed [15:0]          s_ray_dir_z,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic [1:0]                  m_status,
    output logic signed [15:0]          m_hit_x,
    output logic signed [15:0]          m_hit_y,
    output logic signed [15:0]          m_hit_z,
    output logic [15:0]                 m_hit_distance,
    output logic [3:0]                  m_hit_box_index,
    output logic                        m_enemy_hit
);
    import rbf_pkg::*;

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    box_entry_t             mem [MAX_BOXES];
    box_entry_t             rd_data_reg;
    box_entry_t             wr_entry;

    logic signed [15:0]     cam_reg [3];
    logic signed [15:0]     dir_reg [3];
    logic signed [15:0]     ctr [3];
    logic [15:0]            ext [3];
    logic [CNT_W-1:0]       box_count_reg;
    logic [IDX_W-1:0]       box_idx_reg;
    logic                   is_full;

    logic signed [CORNER_W-1:0] lo_s, hi_s;
    logic signed [15:0]     o_s, d_s;
    logic signed [DIFF_W-1:0] diff_lo, diff_hi, div_num, o2_ext;
    logic [QUO_W-1:0]       num_mag;
    logic [15:0]            d_mag;
    logic [20:0]            num_sh;

    logic                   div_busy_reg, div_done_reg, div_neg_reg, div_sat_reg;
    logic                   div_hi_reg;
    logic [4:0]             div_cnt_reg;
    logic [16:0]            div_rem_reg, rem_sh;
    logic [QUO_W-1:0]       div_quo_reg, q_mag;
    logic [15:0]            div_dmag_reg;
    logic                   rem_ge;
    logic signed [SLAB_W-1:0] q_val, a_reg, en_reg, ex_reg;
    logic signed [SLAB_W-1:0] lo_t, hi_t, en_n, ex_n, t_sel;
    logic [15:0]            t_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [10:0]     q_pt;
    logic signed [16:0]     pt_sum;
    logic signed [15:0]     pt_sat;
    logic signed [15:0]     hit_reg [3];

    logic                   m_valid_reg;
    logic [1:0]             m_status_reg;
    logic signed [15:0]     m_hit_reg [3];
    logic [15:0]            m_dist_reg;
    logic [3:0]             m_idx_reg;
    logic                   m_enemy_reg;

    assign ctr[0] = s_box_center_x;
    assign ctr[1] = s_box_center_y;
    assign ctr[2] = s_box_center_z;
    assign ext[0] = s_box_extent_x;
    assign ext[1] = s_box_extent_y;
    assign ext[2] = s_box_extent_z;

    // Corners in half-LSB units: 2*centre -/+ full size, exact in 18 bits.
    always_comb begin
        wr_entry.enemy = s_box_is_enemy;
        for (int k = 0; k < 3; k++) begin
            wr_entry.lo[k] = CORNER_W'($signed({ctr[k][15], ctr[k], 1'b0})
                                       - $signed({2'b00, ext[k]}));
            wr_entry.hi[k] = CORNER_W'($signed({ctr[k][15], ctr[k], 1'b0})
                                       + $signed({2'b00, ext[k]}));
        end
    end

    assign is_full = (box_count_reg == CNT_W'(MAX_BOXES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                cam_reg[k] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CAMERA_X: cam_reg[0] <= cfg_wdata;
                CFG_CAMERA_Y: cam_reg[1] <= cfg_wdata;
                CFG_CAMERA_Z: cam_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && (s_func == FUNC_ADD) && !is_full) begin
            mem[box_count_reg[IDX_W-1:0]] <= wr_entry;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[box_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_count_reg <= '0;
            box_idx_reg   <= '0;
        end else begin
            if (cmd.accept && (s_func == FUNC_ADD) && !is_full) begin
                box_count_reg <= box_count_reg + 1'b1;
            end
            if (cmd.accept) begin
                box_idx_reg <= '0;
            end else if (cmd.next_box) begin
                box_idx_reg <= box_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            dir_reg[0] <= s_ray_dir_x;
            dir_reg[1] <= s_ray_dir_y;
            dir_reg[2] <= s_ray_dir_z;
        end
    end

    // Slab operands of the current axis.
    always_comb begin
        lo_s    = $signed(rd_data_reg.lo[cmd.axis]);
        hi_s    = $signed(rd_data_reg.hi[cmd.axis]);
        o_s     = cam_reg[cmd.axis];
        d_s     = dir_reg[cmd.axis];
        o2_ext  = $signed({{2{o_s[15]}}, o_s, 1'b0});
        diff_lo = $signed({lo_s[CORNER_W-1], lo_s}) - o2_ext;
        diff_hi = $signed({hi_s[CORNER_W-1], hi_s}) - o2_ext;
        div_num = cmd.div_hi ? diff_hi : diff_lo;
        num_mag = div_num[DIFF_W-1] ? QUO_W'(-div_num) : QUO_W'(div_num);
        d_mag   = d_s[15] ? 16'(-d_s) : 16'(d_s);
        num_sh  = {num_mag, 3'b000};
    end

    // Restoring divider, one quotient bit a cycle. A quotient that would not
    // fit in 18 bits saturates; only its order against the others matters.
    assign rem_sh = {div_rem_reg[15:0], 1'b0};
    assign rem_ge = (rem_sh >= {1'b0, div_dmag_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else begin
            div_done_reg <= 1'b0;
            if (cmd.div_start) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= 5'(QUO_W);
            end else if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_cnt_reg == 5'd1) begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_rem_reg  <= 17'(num_sh);
            div_quo_reg  <= '0;
            div_dmag_reg <= d_mag;
            div_neg_reg  <= div_num[DIFF_W-1] ^ d_s[15];
            div_sat_reg  <= (num_sh >= {5'b00000, d_mag});
            div_hi_reg   <= cmd.div_hi;
        end else if (div_busy_reg) begin
            div_rem_reg <= rem_ge ? (rem_sh - {1'b0, div_dmag_reg}) : rem_sh;
            div_quo_reg <= {div_quo_reg[QUO_W-2:0], rem_ge};
        end
        if (div_done_reg && !div_hi_reg) begin
            a_reg <= q_val;
        end
    end

    assign q_mag = div_sat_reg ? {QUO_W{1'b1}} : div_quo_reg;
    assign q_val = div_neg_reg ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});

    // Interval update with the low-corner result held and the high one live.
    always_comb begin
        lo_t  = (a_reg < q_val) ? a_reg : q_val;
        hi_t  = (a_reg < q_val) ? q_val : a_reg;
        en_n  = (lo_t > en_reg) ? lo_t : en_reg;
        ex_n  = (hi_t < ex_reg) ? hi_t : ex_reg;
        t_sel = en_reg[SLAB_W-1] ? ex_reg : en_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            en_reg <= T_NEG_INF;
            ex_reg <= T_POS_INF;
        end else if (cmd.upd) begin
            en_reg <= en_n;
            ex_reg <= ex_n;
        end
        if (cmd.chk) begin
            t_reg <= t_sel[15:0];
        end
    end

    // Hit point: product floored to Q8.8, then saturating add to the origin.
    always_comb begin
        q_pt   = prod_reg[PROD_W-1:22];
        pt_sum = $signed({o_s[15], o_s}) + $signed({{6{q_pt[10]}}, q_pt});
        if (pt_sum[16] != pt_sum[15]) begin
            pt_sat = pt_sum[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            pt_sat = pt_sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= d_s * $signed({1'b0, t_reg});
        end
        if (cmd.acc) begin
            hit_reg[cmd.axis] <= pt_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= cmd.result;
            if (cmd.result == ST_HIT) begin
                for (int k = 0; k < 3; k++) begin
                    m_hit_reg[k] <= hit_reg[k];
                end
                m_dist_reg  <= t_reg;
                m_idx_reg   <= 4'(box_idx_reg);
                m_enemy_reg <= rd_data_reg.enemy;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    m_hit_reg[k] <= '0;
                end
                m_dist_reg  <= '0;
                m_idx_reg   <= '0;
                m_enemy_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_hit_x         = m_hit_reg[0];
    assign m_hit_y         = m_hit_reg[1];
    assign m_hit_z         = m_hit_reg[2];
    assign m_hit_distance  = m_dist_reg;
    assign m_hit_box_index = m_idx_reg;
    assign m_enemy_hit     = m_enemy_reg;

    always_comb begin
        stat.is_full    = is_full;
        stat.count_zero = (box_count_reg == '0);
        stat.last_box   = ((CNT_W'(box_idx_reg) + 1'b1) == box_count_reg);
        stat.d_zero     = (d_s == '0);
        stat.in_slab    = (diff_lo[DIFF_W-1] || (diff_lo == '0)) && !diff_hi[DIFF_W-1];
        stat.div_done   = div_done_reg;
        stat.slab_miss  = (en_n > ex_n);
        stat.t_hit      = (t_sel[SLAB_W-1:16] == '0) && (t_sel[15:0] != '0);
        stat.out_free   = !m_valid_reg || m_ready;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        box_count_reg <= CNT_W'(MAX_BOXES))
        else $error("box count above table depth");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy_reg)
        else $error("division started while divider busy");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result word overwritten before it was taken");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done_reg |=> !div_done_reg)
        else $error("divider done held longer than one cycle");
`endif

endmodule

/* rtl/core/rbf_ctrl.sv */
// ----------------------------------------------------------------------------
// rbf_ctrl: sequencer of the ray/box first-hit finder
// Walks each stored box axis by axis, drives the divider and the hit point
// multiplier, and hands the result word to the output register.
// ----------------------------------------------------------------------------
module rbf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_func,
    output logic               s_ready,
    output rbf_pkg::dp_cmd_t   cmd,
    input  rbf_pkg::dp_stat_t  stat
);
    import rbf_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD    = 11'b00000000010,
        S_AXIS  = 11'b00000000100,
        S_WAITA = 11'b00000001000,
        S_WAITB = 11'b00000010000,
        S_UPD   = 11'b00000100000,
        S_CHECK = 11'b00001000000,
        S_NEXT  = 11'b00010000000,
        S_MUL   = 11'b00100000000,
        S_ACC   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [1:0] result_reg, result_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            axis_reg   <= AXIS_X;
            result_reg <= ST_MISS;
        end else begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            result_reg <= result_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        result_next = result_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        cmd.axis    = axis_reg;
        cmd.result  = result_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_func == FUNC_ADD) begin
                        result_next = stat.is_full ? ST_FULL : ST_ADDED;
                        state_next  = S_DONE;
                    end else if (stat.count_zero) begin
                        result_next = ST_MISS;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                cmd.rd     = 1'b1;
                axis_next  = AXIS_X;
                state_next = S_AXIS;
            end
            S_AXIS: begin
                if (stat.d_zero) begin
                    if (!stat.in_slab) begin
                        state_next = S_NEXT;
                    end else if (axis_reg == AXIS_Z) begin
                        state_next = S_CHECK;
                    end else begin
                        axis_next = axis_reg + 1'b1;
                    end
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_WAITA;
                end
            end
            S_WAITA: begin
                if (stat.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_hi    = 1'b1;
                    state_next    = S_WAITB;
                end
            end
            S_WAITB: begin
                if (stat.div_done) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                cmd.upd = 1'b1;
                if (stat.slab_miss) begin
                    state_next = S_NEXT;
                end else if (axis_reg == AXIS_Z) begin
                    state_next = S_CHECK;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_AXIS;
                end
            end
            S_CHECK: begin
                cmd.chk = 1'b1;
                if (stat.t_hit) begin
                    axis_next   = AXIS_X;
                    result_next = ST_HIT;
                    state_next  = S_MUL;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                if (stat.last_box) begin
                    result_next = ST_MISS;
                    state_next  = S_DONE;
                end else begin
                    cmd.next_box = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                if (axis_reg == AXIS_Z) begin
                    state_next = S_DONE;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == S_DONE || state_reg == S_RD))
        else $error("accepted word did not start work");
    a_hit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> (result_reg == ST_HIT))
        else $error("hit point computed without a hit");
    a_upd_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |-> $past(stat.div_done))
        else $error("interval updated before division finished");
`endif

endmodule

/* rtl/core/ray_box_first_hit_finder_core.sv */
// ----------------------------------------------------------------------------
// ray_box_first_hit_finder_core: first hit of a camera ray on a box table
// Stores axis-aligned boxes and casts rays against them with the slab test.
// ----------------------------------------------------------------------------
// Use of the block:
// The input channel (s_*) takes one word per item. An add word (func 0)
// stores a box given by centre, full size and enemy flag; the answer is
// "added", or "table full" once MAX_BOXES boxes are held. A cast word
// (func 1) gives a ray direction; the ray starts at the camera position held
// in the configuration registers. These must be written by the user through
// cfg_we, cfg_index and cfg_wdata only while the block is idle; the block
// itself does not enforce this. Every input word yields exactly one result
// word on the m_* channel. An add, or a cast on an empty table, goes straight
// to the done state. A cast walks each box: a table read, then per axis
// two 18-step serial divisions and an interval update. A zero direction
// component skips the divisions and only tests the origin against the slab,
// a slab miss cuts the box short, and the hit box adds a multiply and add
// per axis for the hit point. The serial divider sets the rate. The next
// word is taken once the result has moved into the output register, even if
// the receiver has not yet taken it. A stalled receiver holds the result
// stable; work then pauses in front of the output register. Reset empties
// the table and zeroes the camera.
// ----------------------------------------------------------------------------
module ray_box_first_hit_finder_core #(
    parameter int MAX_BOXES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic signed [15:0] s_box_center_x,
    input  logic signed [15:0] s_box_center_y,
    input  logic signed [15:0] s_box_center_z,
    input  logic [15:0]        s_box_extent_x,
    input  logic [15:0]        s_box_extent_y,
    input  logic [15:0]        s_box_extent_z,
    input  logic               s_box_is_enemy,
    input  logic signed [15:0] s_ray_dir_x,
    input  logic signed [15:0] s_ray_dir_y,
    input  logic signed [15:0] s_ray_dir_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [15:0] m_hit_x,
    output logic signed [15:0] m_hit_y,
    output logic signed [15:0] m_hit_z,
    output logic [15:0]        m_hit_distance,
    output logic [3:0]         m_hit_box_index,
    output logic               m_enemy_hit
);
    import rbf_pkg::*;

    // Commands flow from the sequencer to the datapath; status flows back.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    rbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // The datapath owns the box table, the camera registers and the output
    // register, so a finished result waits there while the next word starts.
    rbf_datapath #(
        .MAX_BOXES (MAX_BOXES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_func          (s_func),
        .s_box_center_x  (s_box_center_x),
        .s_box_center_y  (s_box_center_y),
        .s_box_center_z  (s_box_center_z),
        .s_box_extent_x  (s_box_extent_x),
        .s_box_extent_y  (s_box_extent_y),
        .s_box_extent_z  (s_box_extent_z),
        .s_box_is_enemy  (s_box_is_enemy),
        .s_ray_dir_x     (s_ray_dir_x),
        .s_ray_dir_y     (s_ray_dir_y),
        .s_ray_dir_z     (s_ray_dir_z),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_status        (m_status),
        .m_hit_x         (m_hit_x),
        .m_hit_y         (m_hit_y),
        .m_hit_z         (m_hit_z),
        .m_hit_distance  (m_hit_distance),
        .m_hit_box_index (m_hit_box_index),
        .m_enemy_hit     (m_enemy_hit)
    );

endmodule
